// ===== sv/rslc_pkg.sv =====
// Shared types and constants for the relay safety lockout controller.
// No dependencies; every other file imports this package.
package rslc_pkg;

  localparam int unsigned TimeW    = 16;
  localparam int unsigned AccW     = 32;
  localparam int unsigned ChgW     = 32;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned LimitW   = 26;
  localparam int unsigned MsPerSec = 1000;

  typedef enum logic [2:0] {
    CMD_OFF    = 3'd0,
    CMD_ON     = 3'd1,
    CMD_TOGGLE = 3'd2,
    CMD_ESTOP  = 3'd3,
    CMD_RESET  = 3'd4,
    CMD_TICK   = 3'd5
  } cmd_e;

  typedef enum logic [2:0] {
    WHY_NONE      = 3'd0,
    WHY_MIN_OFF   = 3'd1,
    WHY_MIN_ON    = 3'd2,
    WHY_INTERLOCK = 3'd3,
    WHY_EMERGENCY = 3'd4,
    WHY_AUTO      = 3'd5
  } reason_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_MIN_OFF   = 3'd0,
    CFG_MIN_ON    = 3'd1,
    CFG_MAX_ON    = 3'd2,
    CFG_ACT_LOW   = 3'd3,
    CFG_IL_ENABLE = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic [2:0] command;
    logic       interlock_other_active;
  } item_t;

  typedef struct packed {
    logic            drive_level;
    logic            output_on;
    logic            status_code;
    logic            lockout_flag;
    logic [2:0]      lock_cause;
    logic            interlock_claim;
    logic            interlock_allowed;
    logic [ChgW-1:0] change_count;
    logic [AccW-1:0] total_on_ms;
  } res_t;

endpackage

// ===== sv/rslc_cmd_if.sv =====
// Command channel interface: valid/ready handshake plus one command transaction.
// Depends on rslc_pkg for field widths.
interface rslc_cmd_if import rslc_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [2:0] command;
  logic       interlock_other_active;

  modport source (output valid, output command, output interlock_other_active, input ready);
  modport sink (input valid, input command, input interlock_other_active, output ready);
endinterface

// ===== sv/rslc_res_if.sv =====
// Result channel interface: valid/ready handshake plus one result transaction.
// Depends on rslc_pkg for field widths.
interface rslc_res_if import rslc_pkg::*; ();
  logic            valid;
  logic            ready;
  logic            drive_level;
  logic            output_on;
  logic            status_code;
  logic            lockout_flag;
  logic [2:0]      lock_cause;
  logic            interlock_claim;
  logic            interlock_allowed;
  logic [ChgW-1:0] change_count;
  logic [AccW-1:0] total_on_ms;

  modport source (
    output valid, output drive_level, output output_on, output status_code,
    output lockout_flag, output lock_cause, output interlock_claim,
    output interlock_allowed, output change_count, output total_on_ms,
    input ready
  );
  modport sink (
    input valid, input drive_level, input output_on, input status_code,
    input lockout_flag, input lock_cause, input interlock_claim,
    input interlock_allowed, input change_count, input total_on_ms,
    output ready
  );
endinterface

// ===== sv/rslc_in_stage.sv =====
// Input register stage: captures one command transaction per cycle unless the downstream stage stalls.
// Depends on rslc_pkg and rslc_cmd_if.
module rslc_in_stage import rslc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  rslc_cmd_if.sink  cmd_i,
  input  logic      advance_i,
  output logic      valid_o,
  output item_t     item_o
);

  logic  valid_q, valid_d;
  item_t item_q;

  assign cmd_i.ready = !valid_q || advance_i;
  assign valid_d     = (cmd_i.valid && cmd_i.ready) || (valid_q && !advance_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.valid && cmd_i.ready) begin
      item_q.command                <= cmd_i.command;
      item_q.interlock_other_active <= cmd_i.interlock_other_active;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

// ===== sv/rslc_engine.sv =====
// Lockout state, configuration registers and next-state logic for one command.
// Depends on rslc_pkg.
module rslc_engine import rslc_pkg::*; #(
  parameter int unsigned COUNTER_WIDTH = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  input  logic                advance_i,
  input  item_t               item_i,
  output res_t                result_o
);

  localparam int unsigned CmpW = (COUNTER_WIDTH > LimitW) ? COUNTER_WIDTH : LimitW;
  localparam int unsigned SumW = ((COUNTER_WIDTH > AccW) ? COUNTER_WIDTH : AccW) + 1;

  logic [TimeW-1:0] min_off_q, min_on_q, max_on_q;
  logic             act_low_q, il_en_q;

  logic                     is_on_q, is_on_d;
  logic                     lock_q, lock_d;
  reason_e                  why_q, why_d;
  logic [COUNTER_WIDTH-1:0] since_on_q, since_on_d;
  logic [COUNTER_WIDTH-1:0] since_off_q, since_off_d;
  logic [ChgW-1:0]          chg_q, chg_d;
  logic [AccW-1:0]          acc_q, acc_d;
  logic                     held_q, held_d;

  logic                     other;
  logic                     do_req, want_on, status;
  logic                     fail_off, fail_on, fail_il, auto_off;
  logic [COUNTER_WIDTH-1:0] since_on_adv, since_off_adv;
  logic [LimitW-1:0]        limit;
  logic [SumW-1:0]          sum;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_off_q <= '0;
      min_on_q  <= '0;
      max_on_q  <= '0;
      act_low_q <= 1'b0;
      il_en_q   <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_MIN_OFF:   min_off_q <= cfg_wdata_i;
        CFG_MIN_ON:    min_on_q  <= cfg_wdata_i;
        CFG_MAX_ON:    max_on_q  <= cfg_wdata_i;
        CFG_ACT_LOW:   act_low_q <= cfg_wdata_i[0];
        CFG_IL_ENABLE: il_en_q   <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  assign other = item_i.interlock_other_active;
  assign limit = LimitW'(max_on_q) * LimitW'(MsPerSec);

  always_comb begin
    since_on_adv  = since_on_q;
    since_off_adv = since_off_q;
    if (cmd_e'(item_i.command) == CMD_TICK) begin
      if (!(&since_on_q)) since_on_adv = since_on_q + 1'b1;
      if (!(&since_off_q)) since_off_adv = since_off_q + 1'b1;
    end
  end

  assign auto_off = (max_on_q != '0) && is_on_q && (CmpW'(since_on_adv) > CmpW'(limit));
  assign sum      = SumW'(acc_q) + SumW'(since_on_adv);

  always_comb begin
    do_req  = 1'b0;
    want_on = 1'b0;
    unique case (cmd_e'(item_i.command))
      CMD_OFF:    do_req = 1'b1;
      CMD_ON:     begin do_req = 1'b1; want_on = 1'b1; end
      CMD_TOGGLE: begin do_req = 1'b1; want_on = !is_on_q; end
      CMD_TICK:   do_req = auto_off;
      default: ;
    endcase
  end

  assign fail_off = want_on && (min_off_q != '0) &&
                    (since_off_adv < COUNTER_WIDTH'(min_off_q));
  assign fail_on  = !want_on && (min_on_q != '0) &&
                    (since_on_adv < COUNTER_WIDTH'(min_on_q));
  assign fail_il  = want_on && il_en_q && other;

  always_comb begin
    is_on_d     = is_on_q;
    lock_d      = lock_q;
    why_d       = why_q;
    since_on_d  = since_on_adv;
    since_off_d = since_off_adv;
    chg_d       = chg_q;
    acc_d       = acc_q;
    held_d      = held_q;
    status      = 1'b0;
    if (do_req) begin
      priority if (fail_off) begin
        lock_d = 1'b1;
        why_d  = WHY_MIN_OFF;
        status = 1'b1;
      end else if (fail_on) begin
        lock_d = 1'b1;
        why_d  = WHY_MIN_ON;
        status = 1'b1;
      end else if (fail_il) begin
        lock_d = 1'b1;
        why_d  = WHY_INTERLOCK;
        status = 1'b1;
      end else begin
        lock_d = 1'b0;
        why_d  = WHY_NONE;
        if (want_on != is_on_q) begin
          is_on_d = want_on;
          chg_d   = chg_q + 1'b1;
          if (want_on) begin
            since_on_d = '0;
            if (il_en_q) held_d = 1'b1;
          end else begin
            since_off_d = '0;
            acc_d = (sum >= SumW'({AccW{1'b1}})) ? {AccW{1'b1}} : sum[AccW-1:0];
            if (il_en_q) held_d = 1'b0;
          end
        end
      end
    end
    unique case (cmd_e'(item_i.command))
      CMD_ESTOP: begin
        is_on_d = 1'b0;
        lock_d  = 1'b1;
        why_d   = WHY_EMERGENCY;
      end
      CMD_RESET: begin
        lock_d = 1'b0;
        why_d  = WHY_NONE;
      end
      CMD_TICK: begin
        status = 1'b0;
        if (auto_off) begin
          lock_d = 1'b1;
          why_d  = WHY_AUTO;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      is_on_q     <= 1'b0;
      lock_q      <= 1'b0;
      why_q       <= WHY_NONE;
      since_on_q  <= '1;
      since_off_q <= '1;
      chg_q       <= '0;
      acc_q       <= '0;
      held_q      <= 1'b0;
    end else if (advance_i) begin
      is_on_q     <= is_on_d;
      lock_q      <= lock_d;
      why_q       <= why_d;
      since_on_q  <= since_on_d;
      since_off_q <= since_off_d;
      chg_q       <= chg_d;
      acc_q       <= acc_d;
      held_q      <= held_d;
    end
  end

  always_comb begin
    result_o.drive_level       = is_on_d ^ act_low_q;
    result_o.output_on         = is_on_d;
    result_o.status_code       = status;
    result_o.lockout_flag      = lock_d;
    result_o.lock_cause        = why_d;
    result_o.interlock_claim   = held_d;
    result_o.interlock_allowed = !il_en_q || !other;
    result_o.change_count      = chg_d;
    result_o.total_on_ms       = acc_d;
  end

endmodule

// ===== sv/rslc_out_stage.sv =====
// Result register stage: holds one result transaction until the sink takes it.
// Depends on rslc_pkg and rslc_res_if.
module rslc_out_stage import rslc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        load_i,
  input  res_t        result_i,
  output logic        free_o,
  rslc_res_if.source  res_o
);

  logic valid_q, valid_d;
  res_t res_q;

  assign free_o  = !valid_q || res_o.ready;
  assign valid_d = load_i || (valid_q && !res_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= result_i;
    end
  end

  assign res_o.valid             = valid_q;
  assign res_o.drive_level       = res_q.drive_level;
  assign res_o.output_on         = res_q.output_on;
  assign res_o.status_code       = res_q.status_code;
  assign res_o.lockout_flag      = res_q.lockout_flag;
  assign res_o.lock_cause        = res_q.lock_cause;
  assign res_o.interlock_claim   = res_q.interlock_claim;
  assign res_o.interlock_allowed = res_q.interlock_allowed;
  assign res_o.change_count      = res_q.change_count;
  assign res_o.total_on_ms       = res_q.total_on_ms;

endmodule

// ===== sv/relay_safety_lockout_controller_core.sv =====
// Top level of the relay safety lockout controller.
// Depends on rslc_pkg, rslc_cmd_if, rslc_res_if, rslc_in_stage, rslc_engine, rslc_out_stage.
//
// Usage:
//   cmd_i carries one command per transaction (off, on, toggle, emergency stop,
//   reset lockout, 1 ms tick) with the interlock group status. res_o returns
//   exactly one result transaction per command, in order: drive level, logical
//   state, busy status, latched lockout and reason, interlock claim/allowed,
//   change count and total on time.
//   Configuration registers (min off, min on, max on seconds, active low,
//   interlock enable) are written through cfg_we_i/cfg_idx_i/cfg_wdata_i
//   while no command is in flight.
//   A command accepted on cmd_i is held in the input register, then in the
//   result register, from which the sink takes it. Throughput: one command
//   per cycle while the receiver does not stall; the state update is a
//   single pass of compare and counter logic.
//   Reset: all state clears, elapsed counters start saturated, both channels
//   empty. When the receiver stalls, the result register holds and the input
//   register takes one more command, then cmd_i.ready drops.
module relay_safety_lockout_controller_core import rslc_pkg::*; #(
  parameter int unsigned COUNTER_WIDTH = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  rslc_cmd_if.sink            cmd_i,
  rslc_res_if.source          res_o
);

  logic  in_valid, out_free, advance;
  item_t item;
  res_t  result;

  assign advance = in_valid && out_free;

  rslc_in_stage u_in_stage (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd_i),
    .advance_i (advance),
    .valid_o   (in_valid),
    .item_o    (item)
  );

  rslc_engine #(
    .COUNTER_WIDTH (COUNTER_WIDTH)
  ) u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .advance_i   (advance),
    .item_i      (item),
    .result_o    (result)
  );

  rslc_out_stage u_out_stage (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (advance),
    .result_i (result),
    .free_o   (out_free),
    .res_o    (res_o)
  );

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps
// Self-checking bench for relay_safety_lockout_controller_core: random idle/stall traffic,
// an in-bench relay predictor and in-order result checks. Depends on rslc_pkg and the
// rslc_cmd_if / rslc_res_if channel interfaces.
module tb_top;
  import rslc_pkg::*;

  localparam int unsigned CntW       = 32;
  localparam int unsigned StallLimit = 1000;
  localparam logic [CntW-1:0] CntMax = '1;
  localparam logic [AccW-1:0] AccMax = '1;
  localparam logic [2:0] CmdUnused6  = 3'd6;
  localparam logic [2:0] CmdUnused7  = 3'd7;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_wdata_i;

  rslc_cmd_if cmd_if ();
  rslc_res_if res_if ();

  relay_safety_lockout_controller_core #(
    .COUNTER_WIDTH(CntW)
  ) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .cmd_i      (cmd_if.sink),
    .res_o      (res_if.source)
  );

  logic [TimeW-1:0] cfg_min_off = '0;
  logic [TimeW-1:0] cfg_min_on  = '0;
  logic [TimeW-1:0] cfg_max_on  = '0;
  logic             cfg_act_low = 1'b0;
  logic             cfg_il_en   = 1'b0;

  logic             relay_is_on  = 1'b0;
  logic             relay_locked = 1'b0;
  reason_e          relay_why    = WHY_NONE;
  logic [CntW-1:0]  since_on     = CntMax;
  logic [CntW-1:0]  since_off    = CntMax;
  logic [ChgW-1:0]  chg_cnt      = '0;
  logic [AccW-1:0]  on_total     = '0;
  logic             group_claim  = 1'b0;

  item_t       queued_cmds[$];
  res_t        pending_status[$];
  int unsigned cmds_sent   = 0;
  int unsigned cmds_taken  = 0;
  int unsigned mismatches  = 0;
  int unsigned idle_cycles = 0;
  int unsigned cmd_gap     = 0;
  int unsigned res_stall   = 0;
  int unsigned cmd_calm    = 0;
  int unsigned res_calm    = 0;
  logic        cmd_fire    = 1'b0;
  logic        res_fire    = 1'b0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic void set_lockout(reason_e why);
    relay_locked = 1'b1;
    relay_why    = why;
  endfunction

  // Return 1 when the switch request is refused.
  function automatic logic switch_request(logic want_on, logic other);
    logic [AccW:0] sum;
    if (want_on && cfg_min_off != '0 && since_off < cfg_min_off) begin
      set_lockout(WHY_MIN_OFF);
      return 1'b1;
    end
    if (!want_on && cfg_min_on != '0 && since_on < cfg_min_on) begin
      set_lockout(WHY_MIN_ON);
      return 1'b1;
    end
    if (want_on && cfg_il_en && other) begin
      set_lockout(WHY_INTERLOCK);
      return 1'b1;
    end
    relay_locked = 1'b0;
    relay_why    = WHY_NONE;
    if (want_on != relay_is_on) begin
      relay_is_on = want_on;
      chg_cnt     = chg_cnt + 1'b1;
      if (want_on) begin
        since_on = '0;
        if (cfg_il_en) group_claim = 1'b1;
      end else begin
        since_off = '0;
        sum       = {1'b0, on_total} + since_on;
        on_total  = sum[AccW] ? AccMax : sum[AccW-1:0];
        if (cfg_il_en) group_claim = 1'b0;
      end
    end
    return 1'b0;
  endfunction

  function automatic res_t step_relay(item_t it);
    res_t r;
    logic busy;
    busy = 1'b0;
    case (it.command)
      CMD_OFF:    busy = switch_request(1'b0, it.interlock_other_active);
      CMD_ON:     busy = switch_request(1'b1, it.interlock_other_active);
      CMD_TOGGLE: busy = switch_request(!relay_is_on, it.interlock_other_active);
      CMD_ESTOP: begin
        relay_is_on = 1'b0;
        set_lockout(WHY_EMERGENCY);
      end
      CMD_RESET: begin
        relay_locked = 1'b0;
        relay_why    = WHY_NONE;
      end
      CMD_TICK: begin
        if (since_on != CntMax) since_on = since_on + 1'b1;
        if (since_off != CntMax) since_off = since_off + 1'b1;
        if (cfg_max_on != '0 && relay_is_on &&
            64'(since_on) > 64'(cfg_max_on) * 64'(MsPerSec)) begin
          void'(switch_request(1'b0, it.interlock_other_active));
          set_lockout(WHY_AUTO);
        end
      end
      default: ;
    endcase
    r.drive_level       = relay_is_on ^ cfg_act_low;
    r.output_on         = relay_is_on;
    r.status_code       = busy;
    r.lockout_flag      = relay_locked;
    r.lock_cause        = relay_why;
    r.interlock_claim   = group_claim;
    r.interlock_allowed = !cfg_il_en || !it.interlock_other_active;
    r.change_count      = chg_cnt;
    r.total_on_ms       = on_total;
    return r;
  endfunction

  // Mostly short gaps, a few long ones, and now and then a stretch with none.
  function automatic int unsigned pick_gap(inout int unsigned calm);
    int unsigned r;
    if (calm != 0) begin
      calm = calm - 1;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      calm = $urandom_range(20, 100);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic item_t random_cmd(logic soak);
    item_t       it;
    int unsigned r;
    r = $urandom_range(0, 99);
    it.interlock_other_active = ($urandom_range(0, 3) == 0);
    if (soak) begin
      if (r < 97) it.command = CMD_TICK;
      else if (r < 99) it.command = CMD_ON;
      else it.command = CMD_RESET;
    end else begin
      if (r < 22) it.command = CMD_OFF;
      else if (r < 44) it.command = CMD_ON;
      else if (r < 60) it.command = CMD_TOGGLE;
      else if (r < 68) it.command = CMD_ESTOP;
      else if (r < 78) it.command = CMD_RESET;
      else if (r < 96) it.command = CMD_TICK;
      else if (r < 98) it.command = CmdUnused6;
      else it.command = CmdUnused7;
    end
    return it;
  endfunction

  task automatic flag_mismatch(string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    mismatches = mismatches + 1;
  endtask

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) flag_mismatch($sformatf("%s exp 0x%0h got 0x%0h", name, want, got));
  endtask

  task automatic queue_cmd(logic [2:0] command, logic other);
    item_t it;
    it.command                = command;
    it.interlock_other_active = other;
    queued_cmds.push_back(it);
    cmds_sent = cmds_sent + 1;
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [CfgDataW-1:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    case (idx)
      CFG_MIN_OFF:   cfg_min_off = val;
      CFG_MIN_ON:    cfg_min_on  = val;
      CFG_MAX_ON:    cfg_max_on  = val;
      CFG_ACT_LOW:   cfg_act_low = val[0];
      CFG_IL_ENABLE: cfg_il_en   = val[0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_config(logic [TimeW-1:0] min_off, logic [TimeW-1:0] min_on,
                            logic [TimeW-1:0] max_on, logic act_low, logic il_en);
    write_reg(CFG_MIN_OFF, min_off);
    write_reg(CFG_MIN_ON, min_on);
    write_reg(CFG_MAX_ON, max_on);
    write_reg(CFG_ACT_LOW, CfgDataW'(act_low));
    write_reg(CFG_IL_ENABLE, CfgDataW'(il_en));
  endtask

  task automatic drain();
    while (cmds_taken != cmds_sent || pending_status.size() != 0) @(negedge clk_i);
  endtask

  task automatic run_random(int unsigned n, logic soak);
    repeat (n) queued_cmds.push_back(random_cmd(soak));
    cmds_sent = cmds_sent + n;
    drain();
  endtask

  always @(negedge clk_i) begin
    item_t nxt;
    if (rst_ni && (!cmd_if.valid || cmd_fire)) begin
      if (cmd_gap != 0) begin
        cmd_gap      <= cmd_gap - 1;
        cmd_if.valid <= 1'b0;
      end else if (queued_cmds.size() != 0) begin
        nxt = queued_cmds.pop_front();
        cmd_if.valid                  <= 1'b1;
        cmd_if.command                <= nxt.command;
        cmd_if.interlock_other_active <= nxt.interlock_other_active;
        cmd_gap                       <= pick_gap(cmd_calm);
      end else begin
        cmd_if.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    int unsigned g;
    if (rst_ni) begin
      g = 0;
      if (res_stall != 0) g = res_stall;
      else if (res_fire) g = pick_gap(res_calm);
      res_if.ready <= (g == 0);
      res_stall    <= (g == 0) ? 0 : g - 1;
    end
  end

  always @(posedge clk_i) begin
    item_t it;
    res_t  want;
    cmd_fire <= cmd_if.valid && cmd_if.ready;
    res_fire <= res_if.valid && res_if.ready;
    if (rst_ni) begin
      if (res_if.valid && res_if.ready) begin
        if (pending_status.size() == 0) begin
          flag_mismatch("result transaction with no command outstanding");
        end else begin
          want = pending_status.pop_front();
          check_field("drive_level", 32'(want.drive_level), 32'(res_if.drive_level));
          check_field("output_on", 32'(want.output_on), 32'(res_if.output_on));
          check_field("status_code", 32'(want.status_code), 32'(res_if.status_code));
          check_field("lockout_flag", 32'(want.lockout_flag), 32'(res_if.lockout_flag));
          check_field("lock_cause", 32'(want.lock_cause), 32'(res_if.lock_cause));
          check_field("interlock_claim", 32'(want.interlock_claim),
                      32'(res_if.interlock_claim));
          check_field("interlock_allowed", 32'(want.interlock_allowed),
                      32'(res_if.interlock_allowed));
          check_field("change_count", want.change_count, res_if.change_count);
          check_field("total_on_ms", want.total_on_ms, res_if.total_on_ms);
        end
      end
      if (cmd_if.valid && cmd_if.ready) begin
        it.command                = cmd_if.command;
        it.interlock_other_active = cmd_if.interlock_other_active;
        pending_status.push_back(step_relay(it));
        cmds_taken = cmds_taken + 1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((cmd_if.valid && cmd_if.ready) || (res_if.valid && res_if.ready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles == StallLimit) begin
        $display("relay_safety_lockout_controller_core regression: fail");
        $finish;
      end
    end
  end

  initial begin
    clk_i                         = 1'b0;
    rst_ni                        = 1'b0;
    cfg_we_i                      = 1'b0;
    cfg_idx_i                     = CFG_MIN_OFF;
    cfg_wdata_i                   = '0;
    cmd_if.valid                  = 1'b0;
    cmd_if.command                = CMD_OFF;
    cmd_if.interlock_other_active = 1'b0;
    res_if.ready                  = 1'b0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    set_config(16'd2, 16'd2, 16'd0, 1'b0, 1'b1);
    queue_cmd(CMD_TICK, 1'b0);
    queue_cmd(CMD_OFF, 1'b1);
    queue_cmd(CMD_ON, 1'b1);
    queue_cmd(CMD_RESET, 1'b0);
    queue_cmd(CMD_ON, 1'b0);
    queue_cmd(CMD_ON, 1'b1);
    queue_cmd(CMD_ON, 1'b0);
    queue_cmd(CMD_OFF, 1'b0);
    queue_cmd(CMD_TICK, 1'b1);
    queue_cmd(CMD_TICK, 1'b0);
    queue_cmd(CMD_OFF, 1'b0);
    queue_cmd(CMD_TOGGLE, 1'b0);
    queue_cmd(CMD_TICK, 1'b0);
    queue_cmd(CMD_TICK, 1'b0);
    queue_cmd(CMD_TOGGLE, 1'b0);
    queue_cmd(CMD_TOGGLE, 1'b0);
    queue_cmd(CMD_ESTOP, 1'b1);
    queue_cmd(CmdUnused6, 1'b1);
    queue_cmd(CmdUnused7, 1'b0);
    queue_cmd(CMD_RESET, 1'b0);
    queue_cmd(CMD_ON, 1'b0);
    queue_cmd(CMD_OFF, 1'b1);
    queue_cmd(CMD_ESTOP, 1'b0);
    drain();

    set_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1);
    run_random(150, 1'b0);

    // hold on past the max on time; the first shutoff attempt is refused by min on time
    set_config(16'd20, 16'd1002, 16'd1, 1'b0, 1'b1);
    queue_cmd(CMD_ON, 1'b0);
    run_random(1250, 1'b1);

    repeat (3) begin
      set_config(TimeW'($urandom_range(0, 6)), TimeW'($urandom_range(0, 6)),
                 TimeW'($urandom_range(0, 2)), 1'($urandom_range(0, 1)),
                 1'($urandom_range(0, 1)));
      run_random(100, 1'b0);
    end

    set_config(16'd0, 16'd0, 16'd0, 1'b0, 1'b0);
    run_random(150, 1'b0);

    repeat (8) @(negedge clk_i);
    if (mismatches == 0) begin
      $display("relay_safety_lockout_controller_core regression: pass");
    end else begin
      $display("relay_safety_lockout_controller_core regression: fail");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/rslc_pkg.sv
sv/rslc_cmd_if.sv
sv/rslc_res_if.sv
sv/rslc_in_stage.sv
sv/rslc_engine.sv
sv/rslc_out_stage.sv
sv/relay_safety_lockout_controller_core.sv
dv/tb_top.sv
